@@ design/vfcm_pkg.sv @@
// shared types and constants of the voxel face culling mesher
package vfcm_pkg;

  localparam int IN_W   = 40;
  localparam int OUT_W  = 40;
  localparam int GRID_W = 5;
  localparam int CNT_W  = 15;
  localparam int FACES  = 6;

  localparam logic [2:0] CMD_STORE   = 3'd0;
  localparam logic [2:0] CMD_TILE    = 3'd1;
  localparam logic [2:0] CMD_TRANS   = 3'd2;
  localparam logic [2:0] CMD_MESH    = 3'd3;
  localparam logic [2:0] CMD_RESTART = 3'd4;

  localparam logic [2:0] FACE_TOP    = 3'd0;
  localparam logic [2:0] FACE_BOTTOM = 3'd1;
  localparam logic [2:0] FACE_PZ     = 3'd2;
  localparam logic [2:0] FACE_NZ     = 3'd3;
  localparam logic [2:0] FACE_PX     = 3'd4;
  localparam logic [2:0] FACE_NX     = 3'd5;

  localparam logic [GRID_W-1:0] GRID_RESET = 5'd16;
  localparam logic [CNT_W-1:0]  CNT_MAX    = 15'h7fff;

  typedef struct packed {
    logic accept;
    logic rd_here;
    logic latch_here;
    logic rd_nbr;
    logic rd_trans;
    logic face_done;
    logic pick;
    logic div_load;
    logic div_step;
    logic emit;
  } vfcm_cmd_t;

  typedef struct packed {
    logic mesh_go;
    logic here_zero;
    logic nbr_out;
    logic last_face;
    logic mask_empty;
    logic div_last;
    logic out_free;
  } vfcm_stat_t;

endpackage

@@ design/vfcm_ctrl.sv @@
// controller state machine of the mesher
module vfcm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  vfcm_pkg::vfcm_stat_t stat,
  output vfcm_pkg::vfcm_cmd_t  cmd
);

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_HERE_RD   = 4'd1;
  localparam logic [3:0] ST_HERE_CHK  = 4'd2;
  localparam logic [3:0] ST_NBR       = 4'd3;
  localparam logic [3:0] ST_NBR_TYPE  = 4'd4;
  localparam logic [3:0] ST_NBR_TRANS = 4'd5;
  localparam logic [3:0] ST_EMIT_SEL  = 4'd6;
  localparam logic [3:0] ST_DIV_LOAD  = 4'd7;
  localparam logic [3:0] ST_DIV_RUN   = 4'd8;
  localparam logic [3:0] ST_EMIT      = 4'd9;

  logic [3:0] state, state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (stat.mesh_go) state_next = ST_HERE_RD;
        end
      end
      ST_HERE_RD: begin
        cmd.rd_here = 1'b1;
        state_next = ST_HERE_CHK;
      end
      ST_HERE_CHK: begin
        cmd.latch_here = 1'b1;
        state_next = stat.here_zero ? ST_IDLE : ST_NBR;
      end
      ST_NBR: begin
        if (stat.nbr_out) begin
          cmd.face_done = 1'b1;
          if (stat.last_face) state_next = ST_EMIT_SEL;
        end else begin
          cmd.rd_nbr = 1'b1;
          state_next = ST_NBR_TYPE;
        end
      end
      ST_NBR_TYPE: begin
        cmd.rd_trans = 1'b1;
        state_next = ST_NBR_TRANS;
      end
      ST_NBR_TRANS: begin
        cmd.face_done = 1'b1;
        state_next = stat.last_face ? ST_EMIT_SEL : ST_NBR;
      end
      ST_EMIT_SEL: begin
        if (stat.mask_empty) begin
          state_next = ST_IDLE;
        end else begin
          cmd.pick = 1'b1;
          state_next = ST_DIV_LOAD;
        end
      end
      ST_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        state_next = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          state_next = ST_EMIT_SEL;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

endmodule

@@ design/vfcm_datapath.sv @@
// stores, neighbour check, tile divider and output register of the mesher
module vfcm_datapath #(
  parameter int SIDE       = 16,
  parameter int TYPE_COUNT = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  vfcm_pkg::vfcm_cmd_t               cmd,
  output vfcm_pkg::vfcm_stat_t              stat,
  input  logic [vfcm_pkg::IN_W-1:0]         in_data,
  input  logic                              cfg_valid,
  input  logic [vfcm_pkg::GRID_W-1:0]       cfg_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [vfcm_pkg::OUT_W-1:0]        out_data,
  output logic                              out_last
);

  localparam int AW = $clog2(SIDE);
  localparam int VW = 3 * AW;
  localparam int TW = $clog2(TYPE_COUNT);

  logic [2:0] in_cmd, in_face;
  logic [3:0] in_x, in_y, in_z;
  logic [7:0] in_type, in_tile;
  logic       in_see;

  assign in_cmd  = in_data[2:0];
  assign in_x    = in_data[6:3];
  assign in_y    = in_data[10:7];
  assign in_z    = in_data[14:11];
  assign in_type = in_data[22:15];
  assign in_face = in_data[25:23];
  assign in_tile = in_data[33:26];
  assign in_see  = in_data[34];

  logic in_inside, type_ok;
  assign in_inside = ({2'b0, in_x} < 6'(SIDE)) && ({2'b0, in_y} < 6'(SIDE))
                     && ({2'b0, in_z} < 6'(SIDE));
  assign type_ok = ({1'b0, in_type} < 9'(TYPE_COUNT));

  logic [3:0]    px, py, pz;
  logic [TW-1:0] here;
  logic [2:0]    f, pick_f;
  logic [5:0]    mask;

  logic [5:0] xe, ye, ze, nx, ny, nz;
  logic [5:0] wxe, wye, wze;
  logic       nbr_out;
  assign xe = {2'b0, px};
  assign ye = {2'b0, py};
  assign ze = {2'b0, pz};
  assign wxe = {2'b0, in_x};
  assign wye = {2'b0, in_y};
  assign wze = {2'b0, in_z};

  always_comb begin
    nx = xe;
    ny = ye;
    nz = ze;
    case (f)
      vfcm_pkg::FACE_TOP:    ny = ye + 6'd1;
      vfcm_pkg::FACE_BOTTOM: ny = ye - 6'd1;
      vfcm_pkg::FACE_PZ:     nz = ze + 6'd1;
      vfcm_pkg::FACE_NZ:     nz = ze - 6'd1;
      vfcm_pkg::FACE_PX:     nx = xe + 6'd1;
      vfcm_pkg::FACE_NX:     nx = xe - 6'd1;
      default: ;
    endcase
  end

  // below zero wraps to 63, which is past any side
  assign nbr_out = (nx >= 6'(SIDE)) || (ny >= 6'(SIDE)) || (nz >= 6'(SIDE));

  logic [VW-1:0] here_addr, nbr_addr, wr_addr;
  assign here_addr = {xe[AW-1:0], ze[AW-1:0], ye[AW-1:0]};
  assign nbr_addr  = {nx[AW-1:0], nz[AW-1:0], ny[AW-1:0]};
  assign wr_addr   = {wxe[AW-1:0], wze[AW-1:0], wye[AW-1:0]};

  always_comb begin
    pick_f = 3'd0;
    for (int i = vfcm_pkg::FACES - 1; i >= 0; i--) begin
      if (mask[i]) pick_f = 3'(i);
    end
  end

  // voxel store
  logic [TW-1:0] vox_mem [2**VW];
  logic [TW-1:0] vox_q;
  always_ff @(posedge clk) begin
    if (cmd.accept && in_cmd == vfcm_pkg::CMD_STORE && in_inside && type_ok)
      vox_mem[wr_addr] <= in_type[TW-1:0];
    if (cmd.rd_here || cmd.rd_nbr)
      vox_q <= vox_mem[cmd.rd_here ? here_addr : nbr_addr];
  end

  // transparency bits
  logic trans_mem [TYPE_COUNT];
  logic trans_q;
  always_ff @(posedge clk) begin
    if (cmd.accept && in_cmd == vfcm_pkg::CMD_TRANS && type_ok)
      trans_mem[in_type[TW-1:0]] <= in_see;
    if (cmd.rd_trans) trans_q <= trans_mem[vox_q];
  end

  // face tiles, eight slots per type
  logic [7:0] tile_mem [TYPE_COUNT * 8];
  logic [7:0] tile_q;
  always_ff @(posedge clk) begin
    if (cmd.accept && in_cmd == vfcm_pkg::CMD_TILE && type_ok
        && in_face < 3'(vfcm_pkg::FACES))
      tile_mem[{in_type[TW-1:0], in_face}] <= in_tile;
    if (cmd.pick) tile_q <= tile_mem[{here, pick_f}];
  end

  logic [vfcm_pkg::GRID_W-1:0] grid, g_eff;
  always_ff @(posedge clk) begin
    if (rst) grid <= vfcm_pkg::GRID_RESET;
    else if (cfg_valid) grid <= cfg_data;
  end
  assign g_eff = (grid == 5'd0) ? 5'd1 : ((grid > 5'd16) ? 5'd16 : grid);

  // restoring divider, one quotient bit a cycle
  logic [7:0] quo;
  logic [4:0] rem;
  logic [2:0] dcnt;
  logic [5:0] trial;
  assign trial = {rem, quo[7]};

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      quo  <= tile_q;
      rem  <= 5'd0;
      dcnt <= 3'd0;
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, g_eff}) begin
        rem <= 5'(trial - {1'b0, g_eff});
        quo <= {quo[6:0], 1'b1};
      end else begin
        rem <= trial[4:0];
        quo <= {quo[6:0], 1'b0};
      end
      dcnt <= dcnt + 3'd1;
    end
  end

  logic [3:0] row;
  assign row = ({1'b0, quo} + 9'd1 >= {4'b0, g_eff}) ? 4'd0
               : 4'(g_eff - 5'd1 - quo[4:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      f    <= 3'd0;
      mask <= 6'd0;
    end else begin
      if (cmd.accept) begin
        px   <= in_x;
        py   <= in_y;
        pz   <= in_z;
        f    <= 3'd0;
        mask <= 6'd0;
      end
      if (cmd.latch_here) here <= vox_q;
      if (cmd.face_done) begin
        mask[f] <= nbr_out | trans_q;
        f <= (f == vfcm_pkg::FACE_NX) ? 3'd0 : f + 3'd1;
      end
      if (cmd.pick) begin
        f <= pick_f;
        mask[pick_f] <= 1'b0;
      end
    end
  end

  logic [vfcm_pkg::CNT_W-1:0] cnt;
  always_ff @(posedge clk) begin
    if (rst) cnt <= '0;
    else if (cmd.accept && in_cmd == vfcm_pkg::CMD_RESTART) cnt <= '0;
    else if (cmd.emit && cnt != vfcm_pkg::CNT_MAX) cnt <= cnt + 15'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.emit) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= {2'b0, cnt, row, rem[3:0], f, pz, py, px};
      out_last <= (mask == 6'd0);
    end
  end

  assign stat.mesh_go    = (in_cmd == vfcm_pkg::CMD_MESH) && in_inside;
  assign stat.here_zero  = (vox_q == '0);
  assign stat.nbr_out    = nbr_out;
  assign stat.last_face  = (f == vfcm_pkg::FACE_NX);
  assign stat.mask_empty = (mask == 6'd0);
  assign stat.div_last   = (dcnt == 3'd7);
  assign stat.out_free   = !out_valid || out_ready;

`ifndef ASSERT_OFF
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("record loaded over an untaken one");
  a_cnt_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(cmd.accept && in_cmd == vfcm_pkg::CMD_RESTART) && !$past(rst)
    |-> cnt >= $past(cnt))
    else $error("face counter went back without restart");
  a_face_range: assert property (@(posedge clk) disable iff (rst)
    f <= vfcm_pkg::FACE_NX)
    else $error("face index past last face");
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> $past(cmd.div_step) || $past(cmd.emit) == 1'b0)
    else $error("record emitted without division");
`endif

endmodule

@@ design/voxel_face_culling_mesher_top.sv @@
// top level of the voxel face culling mesher
// Store, tile, transparency and restart requests are handled as they are accepted.
// A mesh request reads its own cell (accept, voxel read, check), then marks each
// neighbour outside the cube as exposed directly or, for a neighbour inside, does
// a voxel read, a transparency read and a mark. It then handles each exposed face
// (tile read, 8-step divider, output load, which waits until the output register
// is free) and ends with a final check of the face mask. The voxel store has a
// single read port and the tile divider yields one quotient bit per cycle. A new
// request is taken while the last record still waits in the output register.
module voxel_face_culling_mesher_top #(
  parameter int SIDE       = 16,
  parameter int TYPE_COUNT = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command, pos_x, pos_y, pos_z, block_type, face_select, tile_index, see_through
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // cell_x, cell_y, cell_z, face_dir, tile_column, tile_row, face_number
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);

  vfcm_pkg::vfcm_cmd_t  cmd;
  vfcm_pkg::vfcm_stat_t stat;

  assign cfg_ready = 1'b1;

  vfcm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  vfcm_datapath #(
    .SIDE       (SIDE),
    .TYPE_COUNT (TYPE_COUNT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (s_axis_tdata),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule
